// ===== design/gbc_pkg.sv =====
// Shared types and constants of the GPIO bank controller.
package gbc_pkg;

    localparam int NUM_BANKS     = 2;
    localparam int PINS_PER_BANK = 32;
    localparam int DATA_W        = 32;

    // Only the top PINS_PER_BANK bits of a bank register exist.
    localparam logic [DATA_W-1:0] PIN_MASK = {DATA_W{1'b1}} << (DATA_W - PINS_PER_BANK);

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_DIR   = 3'd0,
        REG_DATA  = 3'd1,
        REG_EVENT = 3'd2,
        REG_MASK  = 3'd3,
        REG_EDGE  = 3'd4
    } reg_sel_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              bank;
        logic [2:0]        reg_sel;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pin_levels;
    } item_t;

    typedef struct packed {
        logic  exec;
        item_t item;
    } gbc_ctl_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
    } gbc_res_t;

endpackage

// ===== design/gbc_regs.sv =====
// Bank register file: executes one read, write or sample tick per cycle in which ctl.exec is set.
module gbc_regs
    import gbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gbc_ctl_t ctl,
    output gbc_res_t res
);

    logic [NUM_BANKS-1:0][DATA_W-1:0] dir_reg,   dir_next;
    logic [NUM_BANKS-1:0][DATA_W-1:0] latch_reg, latch_next;
    logic [NUM_BANKS-1:0][DATA_W-1:0] event_reg, event_next;
    logic [NUM_BANKS-1:0][DATA_W-1:0] mask_reg,  mask_next;
    logic [NUM_BANKS-1:0][DATA_W-1:0] edge_reg,  edge_next;
    logic [NUM_BANKS-1:0][DATA_W-1:0] level_reg, level_next;

    always_comb
    begin
        logic [DATA_W-1:0] new_lv;
        logic [DATA_W-1:0] changed;
        logic [DATA_W-1:0] falling;
        logic [DATA_W-1:0] hit;
        logic [DATA_W-1:0] rd;
        logic              any;
        dir_next   = dir_reg;
        latch_next = latch_reg;
        event_next = event_reg;
        mask_next  = mask_reg;
        edge_next  = edge_reg;
        level_next = level_reg;
        new_lv     = ctl.item.pin_levels & PIN_MASK;
        changed    = '0;
        falling    = '0;
        hit        = '0;
        rd         = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (ctl.exec && (32'(ctl.item.bank) == 32'(b)))
            begin
                unique case (ctl.item.cmd)
                    CMD_READ:
                    begin
                        unique case (ctl.item.reg_sel)
                            REG_DIR:   rd = dir_reg[b];
                            REG_DATA:  rd = (latch_reg[b] & dir_reg[b])
                                          | (level_reg[b] & ~dir_reg[b]);
                            REG_EVENT: rd = event_reg[b];
                            REG_MASK:  rd = mask_reg[b];
                            REG_EDGE:  rd = edge_reg[b];
                            default:   rd = '0;
                        endcase
                    end
                    CMD_WRITE:
                    begin
                        unique case (ctl.item.reg_sel)
                            REG_DIR:   dir_next[b]   = ctl.item.write_data & PIN_MASK;
                            REG_DATA:  latch_next[b] = ctl.item.write_data & PIN_MASK;
                            REG_EVENT: event_next[b] = event_reg[b] & ~ctl.item.write_data;
                            REG_MASK:  mask_next[b]  = ctl.item.write_data & PIN_MASK;
                            REG_EDGE:  edge_next[b]  = ctl.item.write_data & PIN_MASK;
                            default:   ;
                        endcase
                    end
                    CMD_TICK:
                    begin
                        // falling-only pins need 1 -> 0, the rest any change; outputs never fire
                        changed       = level_reg[b] ^ new_lv;
                        falling       = level_reg[b] & ~new_lv;
                        hit           = ((edge_reg[b] & falling) | (~edge_reg[b] & changed))
                                      & ~dir_reg[b] & PIN_MASK;
                        event_next[b] = event_reg[b] | hit;
                        level_next[b] = new_lv;
                    end
                    default: ;
                endcase
            end
        end
        any = 1'b0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            any = any | (|(event_next[b] & mask_next[b]));
        end
        res.read_data = rd & PIN_MASK;
        res.irq       = any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= '0;
            latch_reg <= '0;
            event_reg <= '0;
            mask_reg  <= '0;
            edge_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            dir_reg   <= dir_next;
            latch_reg <= latch_next;
            event_reg <= event_next;
            mask_reg  <= mask_next;
            edge_reg  <= edge_next;
            level_reg <= level_next;
        end
    end

    a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && ctl.item.cmd == CMD_READ) |=>
            ($stable(event_reg) && $stable(level_reg) && $stable(dir_reg)))
        else $error("read changed bank state");

    a_idle_keeps_events: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.exec |=> $stable(event_reg))
        else $error("event bits changed without a transfer");

    a_levels_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.exec && ctl.item.cmd == CMD_TICK) |=> $stable(level_reg))
        else $error("sampled levels changed outside a tick");

endmodule

// ===== design/gpio_bank_controller_core.sv =====
// Top level of the GPIO bank controller: input register, bank registers, result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------------
//  in      | in_valid  | in_stall  | cmd, bank, reg_sel, write_data, pin_levels
//  out     | out_valid | out_stall | read_data, interrupt_request
//
// One transfer per clock sustained while out_stall is low; a result passes through the input
// register, then the result register, and is set by the single bank update pass.
// Reset clears all bank registers to zero and empties both stages.
// A stalled result holds; the input register keeps taking transfers while the
// result register is free or being drained.
module gpio_bank_controller_core
    import gbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic              bank,
    input  logic [2:0]        reg_sel,
    input  logic [DATA_W-1:0] write_data,
    input  logic [DATA_W-1:0] pin_levels,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_data,
    output logic              interrupt_request
);

    logic              item_valid_reg, item_valid_next;
    item_t             item_reg;
    logic              res_valid_reg, res_valid_next;
    logic [DATA_W-1:0] read_data_reg;
    logic              irq_reg;
    logic              accept;
    logic              res_free;
    logic              advance;
    gbc_ctl_t          ctl;
    gbc_res_t          res;

    assign res_free = !res_valid_reg || !out_stall;
    assign advance  = item_valid_reg && res_free;
    assign in_stall = item_valid_reg && !res_free;
    assign accept   = in_valid && !in_stall;

    assign item_valid_next = accept || (item_valid_reg && !advance);
    assign res_valid_next  = advance || (res_valid_reg && out_stall);

    assign ctl.exec = advance;
    assign ctl.item = item_reg;

    gbc_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd        <= cmd;
            item_reg.bank       <= bank;
            item_reg.reg_sel    <= reg_sel;
            item_reg.write_data <= write_data;
            item_reg.pin_levels <= pin_levels;
        end
        if (advance)
        begin
            read_data_reg <= res.read_data;
            irq_reg       <= res.irq;
        end
    end

    assign out_valid         = res_valid_reg;
    assign read_data         = read_data_reg;
    assign interrupt_request = irq_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && res_valid_reg && out_stall))
        else $error("input stalled with room downstream");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("executed item produced no result");

    a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.cmd != CMD_READ) |=> (read_data_reg == '0))
        else $error("non-read transfer returned data");

endmodule
